// ===== rtl/core/ddd_pkg.sv =====
// Shared types, constants and calendar functions for the date day difference block.
package ddd_pkg;

    // Request transaction: two Gregorian dates.
    typedef struct packed {
        logic [13:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [13:0] end_year;
        logic [3:0]  end_month;
        logic [4:0]  end_day;
    } ddd_req_t;

    // Result transaction: signed day count and status code.
    typedef struct packed {
        logic signed [22:0] day_difference;
        logic [1:0]         status;
    } ddd_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       reduce;
        logic [2:0] reduce_idx;
        logic       init;
        logic       step;
        logic       finish_check;
        logic       finish_loop;
    } ddd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dates_ok;
        logic years_done;
    } ddd_sts_t;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_START = 2'd1;
    localparam logic [1:0] STATUS_BAD_END   = 2'd2;
    localparam logic [1:0] STATUS_ORDER     = 2'd3;

    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [2:0]  REDUCE_LAST  = 3'd5;
    localparam logic [8:0]  CYCLE_LAST   = 9'd399;
    localparam logic [22:0] YEAR_DAYS    = 23'd365;
    localparam logic [22:0] LEAP_DAYS    = 23'd366;

    // Restoring reduction constants: 400 shifted left by five down to zero.
    function automatic logic [13:0] reduce_const(input logic [2:0] idx);
        logic [13:0] val;
        case (idx)
            3'd0:    val = 14'd12800;
            3'd1:    val = 14'd6400;
            3'd2:    val = 14'd3200;
            3'd3:    val = 14'd1600;
            3'd4:    val = 14'd800;
            default: val = 14'd400;
        endcase
        return val;
    endfunction

    // Leap test from the year modulo 400.
    function automatic logic leap_from_rem(input logic [8:0] r);
        logic [8:0] r100;
        if (r >= 9'd300)
        begin
            r100 = r - 9'd300;
        end
        else if (r >= 9'd200)
        begin
            r100 = r - 9'd200;
        end
        else if (r >= 9'd100)
        begin
            r100 = r - 9'd100;
        end
        else
        begin
            r100 = r;
        end
        return ((r[1:0] == 2'd0) && (r100 != 9'd0)) || (r == 9'd0);
    endfunction

    // Length of a month; zero for codes that are no month.
    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the year before the first of a month.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // Day of the year for a valid date.
    function automatic logic [8:0] day_of_year(input logic [3:0] m, input logic [4:0] d,
                                               input logic leap);
        logic [8:0] n;
        n = days_before(m) + {4'd0, d};
        if ((m > 4'd2) && leap)
        begin
            n = n + 9'd1;
        end
        return n;
    endfunction

    // Full date check.
    function automatic logic date_valid(input logic [13:0] y, input logic [3:0] m,
                                        input logic [4:0] d, input logic leap);
        return (y != 14'd0) && (y <= YEAR_MAX) && (d != 5'd0)
            && (d <= month_length(m, leap));
    endfunction

endpackage

// ===== rtl/core/ddd_ctrl.sv =====
// Controller state machine that sequences the date difference datapath.
module ddd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ddd_pkg::ddd_sts_t sts,
    output ddd_pkg::ddd_cmd_t cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_LOOP
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       done_reg, done_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.reduce_idx = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = 3'd0;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (idx_reg == ddd_pkg::REDUCE_LAST)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            S_CHECK:
            begin
                if (sts.dates_ok)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_LOOP;
                end
                else
                begin
                    cmd.finish_check = 1'b1;
                    done_next        = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_LOOP:
            begin
                if (sts.years_done)
                begin
                    cmd.finish_loop = 1'b1;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== rtl/core/ddd_datapath.sv =====
// Datapath: year reduction, date checks and the year accumulation loop.
module ddd_datapath (
    input  logic              clk,
    input  ddd_pkg::ddd_req_t request,
    input  ddd_pkg::ddd_cmd_t cmd,
    output ddd_pkg::ddd_sts_t sts,
    output ddd_pkg::ddd_res_t result
);

    ddd_pkg::ddd_req_t  req_reg;
    logic [13:0]        rem1_reg, rem2_reg;
    logic [13:0]        yr_reg;
    logic [8:0]         cyc_reg;
    logic signed [22:0] acc_reg;
    ddd_pkg::ddd_res_t  result_reg;

    logic [13:0]        step_val;
    logic               leap1, leap2, leap_run;
    logic               ok1, ok2;
    logic [1:0]         check_code;
    logic [8:0]         doy1, doy2;
    logic signed [22:0] diff_init;

    // Date checks once both years are reduced modulo 400.
    always_comb
    begin
        step_val = ddd_pkg::reduce_const(cmd.reduce_idx);
        leap1    = ddd_pkg::leap_from_rem(rem1_reg[8:0]);
        leap2    = ddd_pkg::leap_from_rem(rem2_reg[8:0]);
        leap_run = ddd_pkg::leap_from_rem(cyc_reg);
        ok1 = ddd_pkg::date_valid(req_reg.start_year, req_reg.start_month,
                                  req_reg.start_day, leap1);
        ok2 = ddd_pkg::date_valid(req_reg.end_year, req_reg.end_month,
                                  req_reg.end_day, leap2);
        if (!ok1)
        begin
            check_code = ddd_pkg::STATUS_BAD_START;
        end
        else if (!ok2)
        begin
            check_code = ddd_pkg::STATUS_BAD_END;
        end
        else if (req_reg.start_year > req_reg.end_year)
        begin
            check_code = ddd_pkg::STATUS_ORDER;
        end
        else
        begin
            check_code = ddd_pkg::STATUS_OK;
        end
        doy1 = ddd_pkg::day_of_year(req_reg.start_month, req_reg.start_day, leap1);
        doy2 = ddd_pkg::day_of_year(req_reg.end_month, req_reg.end_day, leap2);
        diff_init = $signed({14'd0, doy2}) - $signed({14'd0, doy1});
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= request;
            rem1_reg <= request.start_year;
            rem2_reg <= request.end_year;
        end
        if (cmd.reduce)
        begin
            if (rem1_reg >= step_val)
            begin
                rem1_reg <= rem1_reg - step_val;
            end
            if (rem2_reg >= step_val)
            begin
                rem2_reg <= rem2_reg - step_val;
            end
        end
        if (cmd.init)
        begin
            acc_reg <= diff_init;
            yr_reg  <= req_reg.start_year;
            cyc_reg <= rem1_reg[8:0];
        end
        if (cmd.step)
        begin
            acc_reg <= acc_reg + $signed(leap_run ? ddd_pkg::LEAP_DAYS : ddd_pkg::YEAR_DAYS);
            yr_reg  <= yr_reg + 14'd1;
            cyc_reg <= (cyc_reg == ddd_pkg::CYCLE_LAST) ? 9'd0 : cyc_reg + 9'd1;
        end
        if (cmd.finish_check)
        begin
            result_reg.day_difference <= '0;
            result_reg.status         <= check_code;
        end
        if (cmd.finish_loop)
        begin
            result_reg.day_difference <= acc_reg;
            result_reg.status         <= ddd_pkg::STATUS_OK;
        end
    end

    assign sts.dates_ok   = (check_code == ddd_pkg::STATUS_OK);
    assign sts.years_done = (yr_reg == req_reg.end_year);
    assign result         = result_reg;

endmodule

// ===== rtl/core/date_day_difference.sv =====
// Top level of the Gregorian date day difference block.
//
// A request transaction is taken at a rising edge where start is high and
// busy is low; the request struct carries both dates. The block then works
// on that one transaction alone and holds busy high until it is done.
// For a valid pair of dates the steps are load, reduction of both years
// modulo 400, one date check, the year loop and one finish step; the year
// loop adds 365 or 366 per cycle for each whole year from start_year to
// end_year. When a date is bad or the years are out of order, the check
// step finishes the transaction and the year loop does not run.
// The result transaction appears on result, marked by done for a single
// cycle; the receiver cannot stall it. A new request may be accepted in
// the same cycle that done is high.
// Reset returns the controller to idle and clears done; no result is lost
// other than one still in progress.
module date_day_difference (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ddd_pkg::ddd_req_t request,
    output logic              busy,
    output logic              done,
    output ddd_pkg::ddd_res_t result
);

    ddd_pkg::ddd_cmd_t cmd;
    ddd_pkg::ddd_sts_t sts;

    // Sequencer.
    ddd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Arithmetic and storage.
    ddd_datapath u_datapath (
        .clk     (clk),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result)
    );

    // The result strobe lasts a single cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted request makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start work");

    // A failed status always comes with a zero difference.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ddd_pkg::STATUS_OK)) |-> (result.day_difference == 23'sd0))
        else $error("nonzero difference with failed status");

    // A finished transaction leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("block busy while presenting a result");

endmodule

// ===== test/date_day_difference_test.sv =====
// Self-checking testbench for the Gregorian date day difference block.
module date_day_difference_test;

    localparam int REQ_BITS = $bits(ddd_pkg::ddd_req_t);

    // Holds the predicted results of accepted requests and checks each result against them.
    class date_scoreboard;
        ddd_pkg::ddd_res_t expected_q[$];
        int                mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function bit is_leap(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // A month code that is no month has length zero, so no day can fit it.
        static function int month_days(int y, int m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return is_leap(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        static function bit date_is_valid(int y, int m, int d);
            return (y >= 1) && (y <= 9999) && (d >= 1) && (d <= month_days(y, m));
        endfunction

        // Day of the year, counted by walking the months before this one.
        static function int day_number(int y, int m, int d);
            int n;
            n = d;
            for (int k = 1; k < m; k++)
            begin
                n += month_days(y, k);
            end
            return n;
        endfunction

        // Leap years in 1..y.
        static function int leaps_upto(int y);
            return y / 4 - y / 100 + y / 400;
        endfunction

        static function ddd_pkg::ddd_res_t predict_difference(ddd_pkg::ddd_req_t r);
            ddd_pkg::ddd_res_t res;
            int                y1;
            int                y2;
            int                diff;
            y1 = int'(r.start_year);
            y2 = int'(r.end_year);
            diff = 0;
            if (!date_is_valid(y1, int'(r.start_month), int'(r.start_day)))
            begin
                res.status = ddd_pkg::STATUS_BAD_START;
            end
            else if (!date_is_valid(y2, int'(r.end_month), int'(r.end_day)))
            begin
                res.status = ddd_pkg::STATUS_BAD_END;
            end
            else if (y1 > y2)
            begin
                res.status = ddd_pkg::STATUS_ORDER;
            end
            else
            begin
                diff = 365 * (y2 - y1) + leaps_upto(y2 - 1) - leaps_upto(y1 - 1)
                     + day_number(y2, int'(r.end_month), int'(r.end_day))
                     - day_number(y1, int'(r.start_month), int'(r.start_day));
                res.status = ddd_pkg::STATUS_OK;
            end
            res.day_difference = 23'(diff);
            return res;
        endfunction

        function void note_request(ddd_pkg::ddd_req_t r);
            expected_q.push_back(predict_difference(r));
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_result(ddd_pkg::ddd_res_t got);
            ddd_pkg::ddd_res_t exp;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %0d/%0d with no request pending",
                                          int'(got.day_difference), got.status));
            end
            else
            begin
                exp = expected_q.pop_front();
                if (got.day_difference !== exp.day_difference)
                begin
                    report_mismatch($sformatf("day_difference got %0d expected %0d",
                                              int'(got.day_difference),
                                              int'(exp.day_difference)));
                end
                if (got.status !== exp.status)
                begin
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              got.status, exp.status));
                end
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    ddd_pkg::ddd_req_t request;
    logic              busy;
    logic              done;
    ddd_pkg::ddd_res_t result;

    date_scoreboard sb = new();

    date_day_difference uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Note each request transaction at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            sb.note_request(request);
        end
    end

    // Check each result transaction in the cycle its strobe is high.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result);
        end
    end

    // Hold the request until an edge accepts it; returns in the accepting time step.
    task send_request(input ddd_pkg::ddd_req_t r);
        request <= r;
        start   <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task send_dates(input int y1, input int m1, input int d1,
                    input int y2, input int m2, input int d2);
        ddd_pkg::ddd_req_t r;
        r.start_year  = 14'(y1);
        r.start_month = 4'(m1);
        r.start_day   = 5'(d1);
        r.end_year    = 14'(y2);
        r.end_month   = 4'(m2);
        r.end_day     = 5'(d2);
        send_request(r);
    endtask

    // Idle the request side; the payload is scrambled to show it is ignored.
    task pause(input int n);
        start   <= 1'b0;
        request <= ddd_pkg::ddd_req_t'(REQ_BITS'({$urandom, $urandom}));
        repeat (n) @(posedge clk);
    endtask

    function automatic void pick_month_day(input int y, output logic [3:0] m,
                                           output logic [4:0] d);
        int mm;
        mm = $urandom_range(1, 12);
        m  = 4'(mm);
        d  = 5'($urandom_range(1, date_scoreboard::month_days(y, mm)));
    endfunction

    // Mostly well-formed date pairs with short spans, some out of order,
    // some with one broken field, and some raw noise.
    function automatic ddd_pkg::ddd_req_t make_random_request();
        ddd_pkg::ddd_req_t r;
        int                kind;
        int                y1;
        int                y2;
        int                len;
        kind = $urandom_range(0, 99);
        y1 = $urandom_range(1, 9999);
        if ($urandom_range(0, 24) == 0)
        begin
            y2 = $urandom_range(y1, 9999);
        end
        else
        begin
            y2 = y1 + $urandom_range(0, 20);
            if (y2 > 9999)
            begin
                y2 = 9999;
            end
        end
        if (kind >= 80 && kind < 88)
        begin
            y2 = $urandom_range(1, 9998);
            y1 = y2 + $urandom_range(1, 20);
            if (y1 > 9999)
            begin
                y1 = 9999;
            end
        end
        r.start_year = 14'(y1);
        r.end_year   = 14'(y2);
        pick_month_day(y1, r.start_month, r.start_day);
        pick_month_day(y2, r.end_month, r.end_day);
        if (kind >= 88 && kind < 94)
        begin
            case ($urandom_range(0, 3))
                0: r.start_month = 4'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(13, 15));
                1: r.end_day = 5'd0;
                2: r.start_year = $urandom_range(0, 1) ? 14'd0
                                                       : 14'($urandom_range(10000, 16383));
                default:
                begin
                    len = date_scoreboard::month_days(y2, int'(r.end_month));
                    r.end_day = (len < 31) ? 5'($urandom_range(len + 1, 31)) : 5'd0;
                end
            endcase
        end
        else if (kind >= 94)
        begin
            r = ddd_pkg::ddd_req_t'(REQ_BITS'({$urandom, $urandom}));
        end
        return r;
    endfunction

    // Main sequence: reset, directed cases, random traffic, drain.
    initial
    begin
        int wait_cycles;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Span extremes and sign of the difference.
        send_dates(2000, 1, 1, 2000, 1, 1);
        send_dates(1, 1, 1, 9999, 12, 31);
        send_dates(1, 1, 2, 1, 1, 1);
        send_dates(2000, 12, 31, 2000, 1, 1);
        send_dates(1999, 12, 31, 2000, 1, 1);
        send_dates(9998, 1, 31, 9999, 12, 31);
        // Leap rules: every fourth year, century, four-century.
        send_dates(2000, 2, 29, 2004, 2, 29);
        send_dates(2400, 2, 29, 2401, 3, 1);
        send_dates(1900, 2, 29, 1900, 3, 1);
        send_dates(2001, 1, 1, 2001, 2, 29);
        // Month and day out of range.
        send_dates(2000, 0, 10, 2000, 1, 1);
        send_dates(2000, 13, 1, 2000, 1, 1);
        send_dates(2000, 1, 1, 2000, 15, 31);
        send_dates(2000, 4, 31, 2000, 5, 1);
        send_dates(2000, 1, 0, 2000, 1, 1);
        send_dates(2000, 1, 1, 2000, 1, 0);
        // Year out of range, both dates bad, all fields zero or all ones.
        send_dates(0, 1, 1, 2000, 1, 1);
        send_dates(2000, 1, 1, 10000, 1, 1);
        send_dates(16383, 15, 31, 16383, 15, 31);
        send_dates(0, 0, 0, 0, 0, 0);
        // Start year after end year, alone and with a bad second date.
        send_dates(2001, 1, 1, 2000, 12, 31);
        send_dates(9999, 12, 31, 1, 1, 1);
        send_dates(2001, 1, 1, 2000, 2, 30);

        // Random traffic; the last stretch runs without idle bursts.
        for (int i = 0; i < 77; i++)
        begin
            if (i < 60 && $urandom_range(0, 2) == 0)
            begin
                pause($urandom_range(1, 14));
            end
            send_request(make_random_request());
        end

        start <= 1'b0;
        @(posedge clk);
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        end

        if (sb.mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
